>>> rtl/core/mrc_pkg.sv
// Package for the MRU replacement cache set: sizes, transaction payload types,
// sequencer states and the storage command struct.
// No dependencies.
`default_nettype none

package mrc_pkg;

    localparam int WAYS       = 16;
    localparam int IDX_BITS   = 4;
    localparam int CNT_BITS   = 5;
    localparam int CAP_BITS   = 5;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    typedef logic [IDX_BITS-1:0]   mrc_idx_t;
    typedef logic [CNT_BITS-1:0]   mrc_cnt_t;
    typedef logic [KEY_BITS-1:0]   mrc_key_t;
    typedef logic [VALUE_BITS-1:0] mrc_value_t;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef struct packed {
        logic       mode;
        mrc_key_t   key;
        mrc_value_t write_value;
    } mrc_req_t;

    typedef struct packed {
        logic       hit;
        mrc_value_t read_value;
        logic       evicted;
    } mrc_rsp_t;

    typedef struct packed {
        mrc_idx_t   rd_addr;
        logic       wr_en;
        mrc_idx_t   wr_addr;
        mrc_key_t   wr_key;
        mrc_value_t wr_value;
    } mrc_store_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } mrc_state_t;

endpackage

`default_nettype wire

>>> rtl/core/mrc_store.sv
// Key and value storage for the cache set: one write port, one registered read port.
// Depends on mrc_pkg.
`default_nettype none

module mrc_store
    import mrc_pkg::*;
(
    input  wire logic           clk,
    input  wire mrc_store_cmd_t cmd,
    output mrc_key_t            rd_key,
    output mrc_value_t          rd_value
);

    mrc_key_t   key_mem   [WAYS];
    mrc_value_t value_mem [WAYS];
    mrc_key_t   rd_key_reg;
    mrc_value_t rd_value_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            key_mem[cmd.wr_addr]   <= cmd.wr_key;
            value_mem[cmd.wr_addr] <= cmd.wr_value;
        end
        rd_key_reg   <= key_mem[cmd.rd_addr];
        rd_value_reg <= value_mem[cmd.rd_addr];
    end

    assign rd_key   = rd_key_reg;
    assign rd_value = rd_value_reg;

endmodule

`default_nettype wire

>>> rtl/core/mrc_ctrl.sv
// Sequencer of the cache set: scans the entries through one key comparator,
// then updates valid bits, occupancy and the most recent pointer.
// Depends on mrc_pkg.
`default_nettype none

module mrc_ctrl
    import mrc_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    input  wire mrc_req_t       req_data,
    output logic                req_stall,
    input  wire logic [CAP_BITS-1:0] eff_capacity,
    input  wire logic           rsp_busy,
    output logic                rsp_load,
    output mrc_rsp_t            rsp_result,
    output mrc_store_cmd_t      store_cmd,
    input  wire mrc_key_t       rd_key,
    input  wire mrc_value_t     rd_value
);

    mrc_state_t         state_reg,      state_next;
    mrc_req_t           item_reg,       item_next;
    mrc_idx_t           idx_reg,        idx_next;
    logic               found_reg,      found_next;
    mrc_idx_t           found_idx_reg,  found_idx_next;
    mrc_value_t         hit_value_reg,  hit_value_next;
    logic               free_found_reg, free_found_next;
    mrc_idx_t           free_idx_reg,   free_idx_next;
    logic [WAYS-1:0]    valid_reg,      valid_next;
    mrc_cnt_t           occ_reg,        occ_next;
    mrc_idx_t           mru_reg,        mru_next;

    logic               match;
    mrc_idx_t           slot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            occ_reg        <= '0;
            mru_reg        <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            occ_reg        <= occ_next;
            mru_reg        <= mru_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        found_idx_reg <= found_idx_next;
        hit_value_reg <= hit_value_next;
        free_idx_reg  <= free_idx_next;
    end

    assign match = valid_reg[idx_reg] && (rd_key == item_reg.key);

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        hit_value_next  = hit_value_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        occ_next        = occ_reg;
        mru_next        = mru_reg;
        slot            = mru_reg;
        req_stall       = 1'b1;
        rsp_load        = 1'b0;
        rsp_result      = '0;
        store_cmd.rd_addr  = idx_reg;
        store_cmd.wr_en    = 1'b0;
        store_cmd.wr_addr  = found_idx_reg;
        store_cmd.wr_key   = item_reg.key;
        store_cmd.wr_value = item_reg.write_value;

        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    item_next       = req_data;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (match)
                begin
                    found_next     = 1'b1;
                    found_idx_next = idx_reg;
                    hit_value_next = rd_value;
                    state_next     = ST_DONE;
                end
                else
                begin
                    if (!valid_reg[idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    if (idx_reg == IDX_BITS'(WAYS - 1))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_DONE:
            begin
                if (!rsp_busy)
                begin
                    rsp_load       = 1'b1;
                    rsp_result.hit = found_reg;
                    state_next     = ST_IDLE;
                    if (item_reg.mode == MODE_READ)
                    begin
                        if (found_reg)
                        begin
                            rsp_result.read_value = hit_value_reg;
                            mru_next              = found_idx_reg;
                        end
                    end
                    else if (found_reg)
                    begin
                        store_cmd.wr_en = 1'b1;
                        mru_next        = found_idx_reg;
                    end
                    else
                    begin
                        if (occ_reg < CNT_BITS'(eff_capacity))
                        begin
                            slot             = free_idx_reg;
                            valid_next[slot] = 1'b1;
                            occ_next         = occ_reg + 1'b1;
                        end
                        else
                        begin
                            rsp_result.evicted = 1'b1;
                        end
                        store_cmd.wr_en   = 1'b1;
                        store_cmd.wr_addr = slot;
                        mru_next          = slot;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/mru_replacement_cache_set.sv
// Top level of the MRU replacement cache set: capacity register, output register,
// sequencer and storage. Depends on mrc_pkg, mrc_store and mrc_ctrl.
//
// Usage:
//   req channel (req_valid, req_stall, req_data): one access, read or write, per
//   transaction. req_stall is high while an access is in progress.
//   rsp channel (rsp_valid, rsp_stall, rsp_data): exactly one result per access.
//   cfg channel (cfg_valid, cfg_ready, cfg_data): writes the capacity register;
//   always ready, to be written only while the block is idle.
// Scan:
//   The entries are scanned in order through a single key comparator behind a
//   registered storage read port, each entry through a read state and a compare
//   state. An access that hits entry k stops the scan there; a miss scans all
//   sixteen entries. The next access is accepted the cycle after the result is
//   loaded, so no new access is taken while one is still in progress.
// Reset: all entries invalid, occupancy and most recent pointer zero, capacity 16.
// Stall: a result held in the output register waits for the receiver; a new
// access may still be accepted and scanned, and waits to load its result.
`default_nettype none

module mru_replacement_cache_set
    import mrc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire mrc_req_t            req_data,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output mrc_rsp_t                 rsp_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CAP_BITS-1:0] cfg_data
);

    logic [CAP_BITS-1:0] cap_reg,       cap_next;
    logic                rsp_valid_reg, rsp_valid_next;
    mrc_rsp_t            rsp_data_reg,  rsp_data_next;

    logic [CAP_BITS-1:0] eff_capacity;
    logic                rsp_busy;
    logic                rsp_load;
    mrc_rsp_t            rsp_result;
    mrc_store_cmd_t      store_cmd;
    mrc_key_t            rd_key;
    mrc_value_t          rd_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    always_comb
    begin
        cap_next       = cap_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (cfg_valid && cfg_ready)
        begin
            cap_next = cfg_data;
        end
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = rsp_result;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_capacity = CAP_BITS'(1);
        end
        else if (cap_reg > CAP_BITS'(WAYS))
        begin
            eff_capacity = CAP_BITS'(WAYS);
        end
        else
        begin
            eff_capacity = cap_reg;
        end
    end

    assign rsp_busy  = rsp_valid_reg && rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;
    assign cfg_ready = 1'b1;

    mrc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_data     (req_data),
        .req_stall    (req_stall),
        .eff_capacity (eff_capacity),
        .rsp_busy     (rsp_busy),
        .rsp_load     (rsp_load),
        .rsp_result   (rsp_result),
        .store_cmd    (store_cmd),
        .rd_key       (rd_key),
        .rd_value     (rd_value)
    );

    mrc_store u_store (
        .clk      (clk),
        .cmd      (store_cmd),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

endmodule

`default_nettype wire
